// File: hw/rtl/lsac_pkg.sv
// Shared types and constants of the LRU set-associative cache simulator.
// No dependencies; every other file of the block imports it.
package lsac_pkg;

   localparam int ADDR_W      = 64;
   localparam int CNT_W       = 32;
   localparam int MAX_SETS    = 1024;
   localparam int SET_IDX_W   = $clog2(MAX_SETS);
   localparam int MAX_WAYS    = 8;
   localparam int WAY_W       = $clog2(MAX_WAYS);
   localparam int MAX_ACCESS_BYTES = 16;

   localparam int OPCODE_W    = 2;
   localparam int SIZE_W      = 5;
   localparam int CFG_SET_W   = 4;
   localparam int CFG_BLOCK_W = 3;
   localparam int CFG_WAYS_W  = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_MISS  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0]              valid;
      logic [MAX_WAYS-1:0][WAY_W-1:0]   rank;
      logic [MAX_WAYS-1:0][ADDR_W-1:0]  tag;
   } set_row_type;

   typedef struct packed {
      outcome_type outcome;
      set_row_type row;
   } lookup_res_type;

endpackage

// File: hw/rtl/lsac_if.sv
// Channel interfaces of the cache simulator: access request, lookup result, register write.
// Depends on lsac_pkg.
interface lsac_req_if import lsac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [ADDR_W-1:0]    address;
   logic [SIZE_W-1:0]    access_size;

   modport source (output valid, opcode, address, access_size, input ready);
   modport sink   (input valid, opcode, address, access_size, output ready);
endinterface

interface lsac_rsp_if import lsac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   outcome_type          outcome;
   logic [ADDR_W-1:0]    block_address;
   logic [CNT_W-1:0]     hit_total;
   logic [CNT_W-1:0]     miss_total;
   logic [CNT_W-1:0]     eviction_total;
   logic                 last_of_access;

   modport source (output valid, outcome, block_address, hit_total, miss_total,
                   eviction_total, last_of_access, input ready);
   modport sink   (input valid, outcome, block_address, hit_total, miss_total,
                   eviction_total, last_of_access, output ready);
endinterface

interface lsac_csr_if import lsac_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/lsac_way_logic.sv
// Hit search, LRU ageing and replacement choice over one set row.
// Depends on lsac_pkg; used by lru_set_assoc_cache_sim_top.
module lsac_way_logic import lsac_pkg::*; (
   input  set_row_type            row_i,
   input  logic [ADDR_W-1:0]      blk_i,
   input  logic [CFG_WAYS_W-1:0]  ways_i,
   output lookup_res_type         res_o
);

   always_comb begin
      logic                  found_hit;
      logic                  found_empty;
      logic                  found_victim;
      logic [WAY_W-1:0]      hit_way;
      logic [WAY_W-1:0]      empty_way;
      logic [WAY_W-1:0]      victim_way;
      logic [WAY_W-1:0]      hit_rank;
      logic [WAY_W-1:0]      best_rank;
      logic [WAY_W-1:0]      slot;
      logic [CFG_WAYS_W-1:0] fill;

      found_hit    = 1'b0;
      found_empty  = 1'b0;
      found_victim = 1'b0;
      hit_way      = '0;
      empty_way    = '0;
      victim_way   = '0;
      best_rank    = '0;
      slot         = '0;
      fill         = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         fill = fill + CFG_WAYS_W'(row_i.valid[w]);
         if (!found_hit && row_i.valid[w] && row_i.tag[w] == blk_i) begin
            found_hit = 1'b1;
            hit_way   = WAY_W'(w);
         end
         if (!found_empty && !row_i.valid[w]) begin
            found_empty = 1'b1;
            empty_way   = WAY_W'(w);
         end
         if (row_i.valid[w] && (!found_victim || row_i.rank[w] > best_rank)) begin
            found_victim = 1'b1;
            victim_way   = WAY_W'(w);
            best_rank    = row_i.rank[w];
         end
      end
      hit_rank = row_i.rank[hit_way];

      res_o.row = row_i;
      if (found_hit) begin
         res_o.outcome = OUT_HIT;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (row_i.valid[w] && row_i.rank[w] < hit_rank) begin
               res_o.row.rank[w] = row_i.rank[w] + 1'b1;
            end
         end
         res_o.row.rank[hit_way] = '0;
      end else begin
         res_o.outcome = (fill < ways_i) ? OUT_MISS : OUT_EVICT;
         slot = (fill < ways_i) ? empty_way : victim_way;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (row_i.valid[w]) begin
               res_o.row.rank[w] = row_i.rank[w] + 1'b1;
            end
         end
         res_o.row.valid[slot] = 1'b1;
         res_o.row.tag[slot]   = blk_i;
         res_o.row.rank[slot]  = '0;
      end
   end

endmodule

// File: hw/rtl/lru_set_assoc_cache_sim_top.sv
// Top level of the LRU set-associative cache simulator: set row memory, block walk, totals.
// Depends on lsac_pkg, lsac_if and lsac_way_logic.
//
// Each access is split into the distinct blocks it touches, in address order (twice for a
// modify), and each block gets one result: hit, miss or miss with eviction, with the running
// saturating totals. All tags, valid bits and LRU ranks of a set sit in one row of a set
// memory with one write port and one registered read port. An access is taken in, then its
// block range is worked out, then each block lookup reads the row and afterwards does the
// read-modify-write and gives its result; a lookup waits while the previous result is not taken.
// After reset all 1024 rows of the set memory are cleared, one row a cycle, during which no
// access is taken; register writes are taken at all times.
module lru_set_assoc_cache_sim_top import lsac_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lsac_req_if.sink  req_ch,
   lsac_rsp_if.source rsp_ch,
   lsac_csr_if.sink  csr_ch
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_LOOKUP = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [SET_IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                    two_pass_ff, two_pass_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       end_addr_ff, end_addr_in;
   logic [ADDR_W-1:0]       first_blk_ff, first_blk_in;
   logic [ADDR_W-1:0]       last_blk_ff, last_blk_in;
   logic [ADDR_W-1:0]       cur_blk_ff, cur_blk_in;
   logic [SET_IDX_W-1:0]    set_idx_ff;
   set_row_type             rd_row_ff;
   logic [CNT_W-1:0]        hit_ff, hit_in;
   logic [CNT_W-1:0]        miss_ff, miss_in;
   logic [CNT_W-1:0]        evict_ff, evict_in;
   logic [CFG_SET_W-1:0]    set_bits_ff;
   logic [CFG_BLOCK_W-1:0]  block_bits_ff;
   logic [CFG_WAYS_W-1:0]   ways_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   outcome_type             rsp_outcome_ff;
   logic [ADDR_W-1:0]       rsp_blk_ff;
   logic                    rsp_last_ff;

   set_row_type             mem [MAX_SETS];

   logic                    req_fire;
   logic                    lookup_fire;
   logic [SIZE_W-1:0]       size_sat;
   logic [ADDR_W-1:0]       blk_mask;
   logic [SET_IDX_W-1:0]    set_mask;
   logic [SET_IDX_W-1:0]    cur_set;
   logic [CFG_WAYS_W-1:0]   ways_eff;
   logic                    is_end;
   lookup_res_type          res;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign lookup_fire  = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready = 1'b1;

   assign size_sat = (req_ch.access_size > SIZE_W'(MAX_ACCESS_BYTES)) ?
                     SIZE_W'(MAX_ACCESS_BYTES) : req_ch.access_size;
   assign blk_mask = {ADDR_W{1'b1}} >> block_bits_ff;
   assign is_end   = (cur_blk_ff == last_blk_ff);
   assign ways_eff = (ways_ff == '0) ? CFG_WAYS_W'(1) :
                     (ways_ff > CFG_WAYS_W'(MAX_WAYS)) ? CFG_WAYS_W'(MAX_WAYS) : ways_ff;

   always_comb begin
      for (int i = 0; i < SET_IDX_W; i++) begin
         set_mask[i] = (CFG_SET_W'(i) < set_bits_ff);
      end
   end
   assign cur_set = cur_blk_ff[SET_IDX_W-1:0] & set_mask;

   lsac_way_logic u_way_logic (
      .row_i  (rd_row_ff),
      .blk_i  (cur_blk_ff),
      .ways_i (ways_eff),
      .res_o  (res)
   );

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      two_pass_in  = two_pass_ff;
      addr_in      = addr_ff;
      end_addr_in  = end_addr_ff;
      first_blk_in = first_blk_ff;
      last_blk_in  = last_blk_ff;
      cur_blk_in   = cur_blk_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      evict_in     = evict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == SET_IDX_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && size_sat != '0) begin
               addr_in     = req_ch.address;
               end_addr_in = req_ch.address + ADDR_W'(size_sat) - ADDR_W'(1);
               two_pass_in = (req_ch.opcode == OP_MODIFY);
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            first_blk_in = addr_ff >> block_bits_ff;
            last_blk_in  = end_addr_ff >> block_bits_ff;
            cur_blk_in   = addr_ff >> block_bits_ff;
            state_in     = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (lookup_fire) begin
               rsp_valid_in = 1'b1;
               case (res.outcome)
                  OUT_HIT: begin
                     hit_in = (hit_ff == '1) ? hit_ff : hit_ff + 1'b1;
                  end
                  OUT_MISS: begin
                     miss_in = (miss_ff == '1) ? miss_ff : miss_ff + 1'b1;
                  end
                  default: begin
                     miss_in  = (miss_ff == '1) ? miss_ff : miss_ff + 1'b1;
                     evict_in = (evict_ff == '1) ? evict_ff : evict_ff + 1'b1;
                  end
               endcase
               if (!is_end) begin
                  cur_blk_in = (cur_blk_ff + 1'b1) & blk_mask;
                  state_in   = ST_READ;
               end else if (two_pass_ff) begin
                  two_pass_in = 1'b0;
                  cur_blk_in  = first_blk_ff;
                  state_in    = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         two_pass_ff   <= 1'b0;
         hit_ff        <= '0;
         miss_ff       <= '0;
         evict_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         set_bits_ff   <= CFG_SET_W'(4);
         block_bits_ff <= CFG_BLOCK_W'(4);
         ways_ff       <= CFG_WAYS_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         two_pass_ff  <= two_pass_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_SET_BITS:   set_bits_ff   <= csr_ch.data[CFG_SET_W-1:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_ch.data[CFG_BLOCK_W-1:0];
               CSR_WAYS:       ways_ff       <= csr_ch.data[CFG_WAYS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      end_addr_ff  <= end_addr_in;
      first_blk_ff <= first_blk_in;
      last_blk_ff  <= last_blk_in;
      cur_blk_ff   <= cur_blk_in;
      if (lookup_fire) begin
         rsp_outcome_ff <= res.outcome;
         rsp_blk_ff     <= cur_blk_ff;
         rsp_last_ff    <= is_end && !two_pass_ff;
      end
   end

   // set row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_idx_ff] <= '0;
      end else if (lookup_fire) begin
         mem[set_idx_ff] <= res.row;
      end
      if (state_ff == ST_READ) begin
         rd_row_ff  <= mem[cur_set];
         set_idx_ff <= cur_set;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.outcome        = rsp_outcome_ff;
   assign rsp_ch.block_address  = rsp_blk_ff;
   assign rsp_ch.hit_total      = hit_ff;
   assign rsp_ch.miss_total     = miss_ff;
   assign rsp_ch.eviction_total = evict_ff;
   assign rsp_ch.last_of_access = rsp_last_ff;

   a_evict_needs_full_set: assert property (@(posedge clock) disable iff (reset)
      (lookup_fire && res.outcome == OUT_EVICT) |->
      ($countones(rd_row_ff.valid) >= ways_eff))
      else $error("eviction from a set that is not full");

   a_valid_never_dropped: assert property (@(posedge clock) disable iff (reset)
      lookup_fire |-> ((res.row.valid & rd_row_ff.valid) == rd_row_ff.valid))
      else $error("lookup cleared a valid line");

   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hit_ff >= $past(hit_ff) && miss_ff >= $past(miss_ff) &&
                evict_ff >= $past(evict_ff)))
      else $error("running total decreased");

   a_result_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("result raised outside a lookup");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the LRU set-associative cache simulator: directed and random
// accesses under several register settings, each result checked against a behavioural model.
// Depends on lsac_pkg, the lsac_*_if interfaces and lru_set_assoc_cache_sim_top.
module tb_top;
   import lsac_pkg::*;

   localparam logic [OPCODE_W-1:0]  OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0]  OP_STORE   = 2'd1;
   localparam logic [OPCODE_W-1:0]  OP_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      outcome_type         outcome;
      logic [ADDR_W-1:0]   block_address;
      logic [CNT_W-1:0]    hits;
      logic [CNT_W-1:0]    misses;
      logic [CNT_W-1:0]    evictions;
      logic                last_of_access;
   } block_result_type;

   logic clock = 1'b0;
   logic reset;

   lsac_req_if req_ch ();
   lsac_rsp_if rsp_ch ();
   lsac_csr_if csr_ch ();

   lru_set_assoc_cache_sim_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cache model
   logic [ADDR_W-1:0]    model_tag   [MAX_SETS][MAX_WAYS];
   logic                 model_valid [MAX_SETS][MAX_WAYS];
   logic [WAY_W-1:0]     model_rank  [MAX_SETS][MAX_WAYS];
   logic [3:0]           model_fill  [MAX_SETS];
   logic [CNT_W-1:0]     model_hits, model_misses, model_evictions;
   logic [CFG_SET_W-1:0]   cfg_set_bits;
   logic [CFG_BLOCK_W-1:0] cfg_block_bits;
   logic [CFG_WAYS_W-1:0]  cfg_ways;

   block_result_type pending_results[$];
   int  mismatch_count = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_stalls = 1'b1;

   function automatic void clear_model();
      for (int s = 0; s < MAX_SETS; s++) begin
         model_fill[s] = '0;
         for (int w = 0; w < MAX_WAYS; w++) begin
            model_valid[s][w] = 1'b0;
            model_rank[s][w]  = '0;
         end
      end
      model_hits      = '0;
      model_misses    = '0;
      model_evictions = '0;
      cfg_set_bits    = 4'd4;
      cfg_block_bits  = 3'd4;
      cfg_ways        = 4'd1;
   endfunction

   function automatic int ways_limit();
      if (cfg_ways == 0) return 1;
      if (cfg_ways > MAX_WAYS) return MAX_WAYS;
      return int'(cfg_ways);
   endfunction

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void age_row(input int unsigned row, input int unsigned limit);
      for (int w = 0; w < MAX_WAYS; w++)
         if (model_valid[row][w] && model_rank[row][w] < limit)
            model_rank[row][w] = model_rank[row][w] + 1'b1;
   endfunction

   function automatic void fill_line(input int unsigned row, input int unsigned slot,
                                     input logic [ADDR_W-1:0] blk);
      age_row(row, MAX_WAYS);
      model_valid[row][slot] = 1'b1;
      model_tag[row][slot]   = blk;
      model_rank[row][slot]  = '0;
   endfunction

   function automatic outcome_type classify_block(input logic [ADDR_W-1:0] blk);
      logic [ADDR_W-1:0] masked;
      int unsigned row, slot;
      masked = blk & ((64'd1 << cfg_set_bits) - 64'd1);
      row    = 32'(masked[SET_IDX_W-1:0]);
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (model_valid[row][w] && model_tag[row][w] == blk) begin
            age_row(row, model_rank[row][w]);
            model_rank[row][w] = '0;
            model_hits = bump(model_hits);
            return OUT_HIT;
         end
      end
      model_misses = bump(model_misses);
      slot = MAX_WAYS;
      if (model_fill[row] < ways_limit())
         for (int w = 0; w < MAX_WAYS; w++)
            if (!model_valid[row][w] && slot == MAX_WAYS) slot = w;
      if (slot < MAX_WAYS) begin
         fill_line(row, slot, blk);
         model_fill[row] = model_fill[row] + 1'b1;
         return OUT_MISS;
      end
      // replace the least recently used line
      for (int w = 0; w < MAX_WAYS; w++)
         if (model_valid[row][w] &&
             (slot == MAX_WAYS || model_rank[row][w] > model_rank[row][slot]))
            slot = w;
      if (slot == MAX_WAYS) slot = 0;
      fill_line(row, slot, blk);
      model_evictions = bump(model_evictions);
      return OUT_EVICT;
   endfunction

   function automatic void predict_access(input logic [OPCODE_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [SIZE_W-1:0] size);
      int unsigned n_bytes, passes, produced;
      logic [ADDR_W-1:0] blk, prev_blk;
      logic have_prev;
      block_result_type res;
      n_bytes  = (size > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : 32'(size);
      passes   = (op == OP_MODIFY) ? 2 : 1;
      produced = 0;
      for (int p = 0; p < passes; p++) begin
         have_prev = 1'b0;
         prev_blk  = '0;
         for (int unsigned off = 0; off < n_bytes; off++) begin
            blk = (addr + 64'(off)) >> cfg_block_bits;
            if (!(have_prev && blk == prev_blk)) begin
               have_prev = 1'b1;
               prev_blk  = blk;
               res.outcome        = classify_block(blk);
               res.block_address  = blk;
               res.hits           = model_hits;
               res.misses         = model_misses;
               res.evictions      = model_evictions;
               res.last_of_access = 1'b0;
               pending_results.push_back(res);
               produced++;
            end
         end
      end
      if (produced > 0)
         pending_results[pending_results.size()-1].last_of_access = 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                                  input logic [ADDR_W-1:0] want);
      mismatch_count++;
      $display("mismatch at %0t on %s: got %h, expected %h", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin
      block_result_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_ch.block_address, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.outcome !== want.outcome)
               report_mismatch("outcome", ADDR_W'(rsp_ch.outcome), ADDR_W'(want.outcome));
            if (rsp_ch.block_address !== want.block_address)
               report_mismatch("block_address", rsp_ch.block_address, want.block_address);
            if (rsp_ch.hit_total !== want.hits)
               report_mismatch("hit_total", ADDR_W'(rsp_ch.hit_total), ADDR_W'(want.hits));
            if (rsp_ch.miss_total !== want.misses)
               report_mismatch("miss_total", ADDR_W'(rsp_ch.miss_total),
                               ADDR_W'(want.misses));
            if (rsp_ch.eviction_total !== want.evictions)
               report_mismatch("eviction_total", ADDR_W'(rsp_ch.eviction_total),
                               ADDR_W'(want.evictions));
            if (rsp_ch.last_of_access !== want.last_of_access)
               report_mismatch("last_of_access", ADDR_W'(rsp_ch.last_of_access),
                               ADDR_W'(want.last_of_access));
         end
      end
   end

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = receiver_stalls ? $urandom_range(0, 6) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && reset === 1'b0));
      end
   end

   task automatic send_access(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [SIZE_W-1:0] size);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.address     <= addr;
      req_ch.access_size <= size;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_access(op, addr, size);
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         CSR_SET_BITS:   cfg_set_bits   = value[CFG_SET_W-1:0];
         CSR_BLOCK_BITS: cfg_block_bits = value[CFG_BLOCK_W-1:0];
         CSR_WAYS:       cfg_ways       = value[CFG_WAYS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // upper data bits carry noise that the block must drop
   task automatic reconfigure(input logic [CFG_SET_W-1:0] sb, input logic [CFG_BLOCK_W-1:0] bb,
                              input logic [CFG_WAYS_W-1:0] wy);
      settle();
      write_register(CSR_SET_BITS,   {4'($urandom), sb});
      write_register(CSR_BLOCK_BITS, {5'($urandom), bb});
      write_register(CSR_WAYS,       {4'($urandom), wy});
   endtask

   task automatic test_reset_defaults();
      send_access(OP_LOAD,   64'h0, 5'd1);
      send_access(OP_LOAD,   64'h0, 5'd1);
      send_access(OP_STORE,  64'h10, 5'd16);
      send_access(OP_LOAD,   64'h100, 5'd1);
      send_access(OP_MODIFY, 64'h8, 5'd16);
      send_access(OP_SPARE,  64'h20, 5'd2);
      send_access(OP_LOAD,   64'h40, 5'd0);
      send_access(OP_STORE,  64'h33, 5'd31);
      send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFF8, 5'd16);
      send_access(OP_LOAD,   '1, 5'd17);
   endtask

   task automatic test_block_widths();
      logic [ADDR_W-1:0] base;
      base = {$urandom, $urandom};
      reconfigure(4'd0, 3'd0, 4'd15);
      send_access(OP_MODIFY, base, 5'd16);
      send_access(OP_LOAD, base, 5'd16);
      reconfigure(4'd4, 3'd7, 4'd1);
      send_access(OP_STORE, 64'h7F8, 5'd16);
   endtask

   task automatic test_shrinking_ways();
      reconfigure(4'd0, 3'd4, 4'd8);
      send_access(OP_LOAD, 64'h00, 5'd1);
      send_access(OP_LOAD, 64'h10, 5'd1);
      send_access(OP_LOAD, 64'h20, 5'd1);
      send_access(OP_LOAD, 64'h30, 5'd1);
      reconfigure(4'd0, 3'd4, 4'd2);
      send_access(OP_LOAD, 64'h20, 5'd1);
      send_access(OP_LOAD, 64'h90, 5'd1);
      reconfigure(4'd0, 3'd4, 4'd0);
      send_access(OP_LOAD, 64'hA0, 5'd1);
      send_access(OP_LOAD, 64'h00, 5'd1);
   endtask

   task automatic test_set_index_wrap();
      reconfigure(4'd15, 3'd0, 4'd1);
      send_access(OP_LOAD, 64'h400, 5'd1);
      send_access(OP_LOAD, 64'h000, 5'd1);
      send_access(OP_LOAD, 64'h400, 5'd1);
      settle();
      write_register(CSR_UNUSED, 8'($urandom));
      send_access(OP_LOAD, 64'h400, 5'd1);
   endtask

   // hot addresses share a few sets and overflow the ways; the rest are anywhere
   task automatic run_random_phase(input int phase, input logic [CFG_SET_W-1:0] sb,
                                   input logic [CFG_BLOCK_W-1:0] bb,
                                   input logic [CFG_WAYS_W-1:0] wy, input int n_items);
      logic [ADDR_W-1:0] hot_base, addr;
      logic [SIZE_W-1:0] size;
      int unsigned pick;
      int tag_shift;
      reconfigure(sb, bb, wy);
      sender_gaps     = (phase % 3) != 0;
      receiver_stalls = (phase % 2) == 0;
      hot_base  = {$urandom, $urandom};
      tag_shift = int'(bb) + int'(sb);
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)
            addr = {$urandom, $urandom};
         else
            addr = hot_base
                 + (64'($urandom_range(0, ways_limit() + 2)) << tag_shift)
                 + (64'($urandom_range(0, 3)) << bb)
                 + 64'($urandom_range(0, (1 << bb) - 1));
         pick = $urandom_range(0, 99);
         if (pick < 5)       size = 5'd0;
         else if (pick < 75) size = 5'($urandom_range(1, 8));
         else if (pick < 90) size = 5'($urandom_range(9, 16));
         else                size = 5'($urandom_range(17, 31));
         send_access(2'($urandom_range(0, 3)), addr, size);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 4'd2,  3'd3, 4'd4,  13);
      run_random_phase(1, 4'd0,  3'd0, 4'd8,  13);
      run_random_phase(2, 4'd10, 3'd6, 4'd2,  13);
      run_random_phase(3, 4'd15, 3'd7, 4'd15, 13);
      run_random_phase(4, 4'd3,  3'd2, 4'd0,  13);
      run_random_phase(5, 4'($urandom), 3'($urandom), 4'($urandom), 13);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_LOAD;
      req_ch.address     = '0;
      req_ch.access_size = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_SET_BITS;
      csr_ch.data        = '0;
      clear_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_block_widths();
      test_shrinking_ways();
      test_set_index_wrap();
      test_random_traffic();
      settle();

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
